@@ design/wmmf_pkg.sv @@
// Shared types and constants of the window mean/median filter.
// Used by every module of the block except wmmf_ram; depends on nothing.
package wmmf_pkg;

	localparam int unsigned DefMaxWidth  = 1024;
	localparam int unsigned DefMaxWindow = 7;
	localparam int unsigned ChanW        = 8;
	localparam int unsigned NumChan      = 3;
	localparam int unsigned PixW         = ChanW * NumChan;

	localparam logic [10:0] WidthReset  = 11'd640;
	localparam logic [15:0] HeightReset = 16'd480;
	localparam logic [2:0]  WsizeReset  = 3'd3;

	localparam logic CMD_PIXEL   = 1'b0;
	localparam logic CMD_DRAIN   = 1'b1;
	localparam logic MODE_MEAN   = 1'b0;
	localparam logic MODE_MEDIAN = 1'b1;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_WSIZE  = 2'd2,
		REG_MODE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [10:0] width;
		logic [15:0] height;
		logic [2:0]  wsize;
		logic        mode;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic restart;
		logic setup;
		logic gather;
		logic prep;
		logic step;
		logic advance;
	} dp_cmd_t;

	typedef struct packed {
		logic emit;
		logic gather_last;
		logic step_last;
	} dp_stat_t;

endpackage

@@ design/wmmf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module wmmf_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/wmmf_dp.sv @@
// Datapath: frame counters, line store, window address walk, sorting cells,
// sums and the shift-subtract divider. Depends on wmmf_pkg and wmmf_ram.
module wmmf_dp import wmmf_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DefMaxWidth,
	parameter int unsigned MAX_WINDOW = DefMaxWindow
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  dp_cmd_t         cmd,
	output dp_stat_t        stat,
	input  logic            pix_cmd,
	input  logic [PixW-1:0] pix_in,
	output logic [PixW-1:0] res_pix,
	output logic            res_last
);

	localparam int unsigned Ring   = MAX_WIDTH * MAX_WINDOW;
	localparam int unsigned AW     = $clog2(Ring);
	localparam int unsigned ExtMax = (MAX_WINDOW - 1) / 2;
	localparam int unsigned EW     = $clog2(ExtMax + 1);
	localparam int unsigned NW     = EW + 1;
	localparam int unsigned Cap    = (2 * ExtMax + 1) * (2 * ExtMax + 1);
	localparam int unsigned CNW    = $clog2(Cap + 1);
	localparam int unsigned SW     = ChanW + CNW;
	localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
	localparam int unsigned CW     = (WW > 11) ? WW : 11;
	localparam int unsigned COLW   = $clog2(MAX_WIDTH);
	localparam int unsigned LW     = $clog2(ExtMax * MAX_WIDTH + ExtMax + 2);
	localparam int unsigned XW     = (EW > 2) ? EW : 2;

	logic [CW-1:0]   width_x;
	logic [WW-1:0]   w_eff;
	logic [15:0]     h_eff;
	logic [1:0]      ext_raw;
	logic [XW-1:0]   ext_x;
	logic [EW-1:0]   ext;
	logic [LW-1:0]   lag;

	assign width_x = CW'(cfg.width);
	assign h_eff   = (cfg.height == 16'd0) ? 16'd1 : cfg.height;
	assign ext_raw = (cfg.wsize == 3'd0) ? 2'd0 : 2'((cfg.wsize - 3'd1) >> 1);
	assign ext_x   = XW'(ext_raw);
	assign ext     = (ext_x > XW'(ExtMax)) ? EW'(ExtMax) : EW'(ext_x);
	assign lag     = LW'(ext) * LW'(w_eff) + LW'(ext);

	always_comb begin
		if (cfg.width == 11'd0) begin
			w_eff = WW'(1);
		end else if (width_x > CW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_x);
		end
	end

	logic [COLW-1:0] in_col_q, out_col_q;
	logic [15:0]     in_row_q, out_row_q;
	logic [LW-1:0]   ahead_q, ahead_inc;
	logic [AW-1:0]   wr_ptr_q, ctr_ptr_q;
	logic            last_q;
	logic            in_done, wr_en, in_col_last, out_col_last;

	assign in_done      = (in_row_q == h_eff);
	assign ahead_inc    = ahead_q + LW'(1);
	assign wr_en        = cmd.take && !in_done && (pix_cmd == CMD_PIXEL);
	assign in_col_last  = (CW'(in_col_q) == CW'(w_eff) - CW'(1));
	assign out_col_last = (CW'(out_col_q) == CW'(w_eff) - CW'(1));
	assign stat.emit    = in_done || ((pix_cmd == CMD_PIXEL) && (ahead_inc > lag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ahead_q   <= '0;
			wr_ptr_q  <= '0;
			ctr_ptr_q <= '0;
		end else if (cmd.restart || (cmd.advance && last_q)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			ahead_q   <= '0;
			wr_ptr_q  <= '0;
			ctr_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(Ring - 1)) ? '0 : wr_ptr_q + AW'(1);
				ahead_q  <= ahead_inc;
				if (in_col_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 16'd1;
				end else begin
					in_col_q <= in_col_q + COLW'(1);
				end
			end
			if (cmd.advance) begin
				ctr_ptr_q <= (ctr_ptr_q == AW'(Ring - 1)) ? '0 : ctr_ptr_q + AW'(1);
				ahead_q   <= ahead_q - LW'(1);
				if (out_col_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 16'd1;
				end else begin
					out_col_q <= out_col_q + COLW'(1);
				end
			end
		end
	end

	// Window geometry around the current output pixel, clipped at the borders.
	logic [EW-1:0] up, dn, lf, rt;
	logic [15:0]   rows_below;
	logic [CW-1:0] cols_right;
	logic [NW-1:0] nrows, ncols;
	logic [AW-1:0] off, start;

	always_comb begin
		rows_below = h_eff - 16'd1 - out_row_q;
		cols_right = CW'(w_eff) - CW'(1) - CW'(out_col_q);
		up = (out_row_q > 16'(ext)) ? ext : EW'(out_row_q);
		dn = (rows_below > 16'(ext)) ? ext : EW'(rows_below);
		lf = (CW'(out_col_q) > CW'(ext)) ? ext : EW'(out_col_q);
		rt = (cols_right > CW'(ext)) ? ext : EW'(cols_right);
		nrows = NW'(up) + NW'(dn) + NW'(1);
		ncols = NW'(lf) + NW'(rt) + NW'(1);
		off   = AW'(up) * AW'(w_eff) + AW'(lf);
		start = (ctr_ptr_q >= off) ? ctr_ptr_q - off : ctr_ptr_q + AW'(Ring) - off;
	end

	logic [NW-1:0]  gr_q, gc_q, nrows_q, ncols_q;
	logic [AW-1:0]  addr_q, base_q, addr_inc, base_wrap;
	logic [AW:0]    base_sum;
	logic [CNW-1:0] cnt_q;
	logic           col_end, rd_v_s1;

	assign base_sum  = {1'b0, base_q} + (AW + 1)'(w_eff);
	assign base_wrap = (base_sum >= (AW + 1)'(Ring)) ? AW'(base_sum - (AW + 1)'(Ring))
	                                                 : AW'(base_sum);
	assign addr_inc  = (addr_q == AW'(Ring - 1)) ? '0 : addr_q + AW'(1);
	assign col_end   = (gc_q == ncols_q - NW'(1));
	assign stat.gather_last = col_end && (gr_q == nrows_q - NW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= cmd.gather;
			if (cmd.setup) begin
				last_q <= (out_row_q == h_eff - 16'd1) && out_col_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			gr_q    <= '0;
			gc_q    <= '0;
			addr_q  <= start;
			base_q  <= start;
			nrows_q <= nrows;
			ncols_q <= ncols;
			cnt_q   <= CNW'(nrows) * CNW'(ncols);
		end else if (cmd.gather) begin
			if (col_end) begin
				gc_q   <= '0;
				gr_q   <= gr_q + NW'(1);
				base_q <= base_wrap;
				addr_q <= base_wrap;
			end else begin
				gc_q   <= gc_q + NW'(1);
				addr_q <= addr_inc;
			end
		end
	end

	logic [PixW-1:0] rd_data;

	wmmf_ram #(
		.WIDTH(PixW),
		.DEPTH(Ring)
	) u_line_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_ptr_q),
		.wdata(pix_in),
		.raddr(addr_q),
		.rdata(rd_data)
	);

	// Insertion-sorted cells per channel; unfilled cells rank above any sample.
	logic [ChanW-1:0] cell_q   [NumChan][Cap];
	logic [ChanW-1:0] prev_val [NumChan][Cap];
	logic [ChanW-1:0] next_val [NumChan][Cap];
	logic             prev_gt  [NumChan][Cap];
	logic             here_gt  [NumChan][Cap];
	logic [ChanW-1:0] smp      [NumChan];
	logic [Cap-1:0]   vld_q;

	always_comb begin
		for (int ch = 0; ch < NumChan; ch++) begin
			smp[ch] = rd_data[ch*ChanW +: ChanW];
			prev_val[ch][0] = '0;
			prev_gt[ch][0]  = 1'b0;
			next_val[ch][Cap-1] = cell_q[ch][Cap-1];
			for (int i = 1; i < Cap; i++) begin
				prev_val[ch][i] = cell_q[ch][i-1];
				prev_gt[ch][i]  = vld_q[i-1] && (cell_q[ch][i-1] > smp[ch]);
			end
			for (int i = 0; i < Cap - 1; i++) begin
				next_val[ch][i] = cell_q[ch][i+1];
			end
			for (int i = 0; i < Cap; i++) begin
				here_gt[ch][i] = !vld_q[i] || (cell_q[ch][i] > smp[ch]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.setup) begin
			vld_q <= '0;
		end else if (rd_v_s1) begin
			vld_q <= {vld_q[Cap-2:0], 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NumChan; ch++) begin
			for (int i = 0; i < Cap; i++) begin
				if (rd_v_s1) begin
					if (here_gt[ch][i]) begin
						cell_q[ch][i] <= prev_gt[ch][i] ? prev_val[ch][i] : smp[ch];
					end
				end else if (cmd.step) begin
					cell_q[ch][i] <= next_val[ch][i];
				end
			end
		end
	end

	// Sums, then either the divider or the walk out of the sorted cells.
	logic [SW-1:0]    sum_q [NumChan];
	logic [CNW-1:0]   rem_q [NumChan];
	logic [ChanW-1:0] quo_q [NumChan];
	logic [ChanW-1:0] med_a_q [NumChan];
	logic [ChanW-1:0] med_b_q [NumChan];
	logic [CNW:0]     trial [NumChan];
	logic [ChanW:0]   med_sum [NumChan];
	logic [CNW-1:0]   j_q, lo, hi;

	assign lo = (cnt_q - CNW'(1)) >> 1;
	assign hi = cnt_q >> 1;
	assign stat.step_last = (cfg.mode == MODE_MEDIAN) ? (j_q == hi) : (j_q == CNW'(ChanW - 1));

	always_comb begin
		for (int ch = 0; ch < NumChan; ch++) begin
			trial[ch]   = {rem_q[ch], quo_q[ch][ChanW-1]};
			med_sum[ch] = {1'b0, med_a_q[ch]} + {1'b0, med_b_q[ch]};
			res_pix[ch*ChanW +: ChanW] = (cfg.mode == MODE_MEDIAN) ? med_sum[ch][ChanW:1]
			                                                       : quo_q[ch];
		end
	end
	assign res_last = last_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			j_q <= '0;
		end else if (cmd.step) begin
			j_q <= j_q + CNW'(1);
		end
		for (int ch = 0; ch < NumChan; ch++) begin
			if (cmd.setup) begin
				sum_q[ch] <= '0;
			end else if (rd_v_s1) begin
				sum_q[ch] <= sum_q[ch] + SW'(smp[ch]);
			end
			if (cmd.prep) begin
				rem_q[ch] <= sum_q[ch][SW-1:ChanW];
				quo_q[ch] <= sum_q[ch][ChanW-1:0];
			end else if (cmd.step) begin
				if (trial[ch] >= {1'b0, cnt_q}) begin
					rem_q[ch] <= CNW'(trial[ch] - {1'b0, cnt_q});
					quo_q[ch] <= {quo_q[ch][ChanW-2:0], 1'b1};
				end else begin
					rem_q[ch] <= CNW'(trial[ch]);
					quo_q[ch] <= {quo_q[ch][ChanW-2:0], 1'b0};
				end
				if (j_q == lo) begin
					med_a_q[ch] <= cell_q[ch][0];
				end
				if (j_q == hi) begin
					med_b_q[ch] <= cell_q[ch][0];
				end
			end
		end
	end

endmodule

@@ design/wmmf_ctrl.sv @@
// Controller state machine of the window filter: sequences one item through
// gather, finish and result hand-off. Depends on wmmf_pkg.
module wmmf_ctrl import wmmf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_free,
	input  logic     cfg_we,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SETUP  = 7'b0000010,
		ST_GATHER = 7'b0000100,
		ST_FLUSH  = 7'b0001000,
		ST_PREP   = 7'b0010000,
		ST_FINISH = 7'b0100000,
		ST_RESULT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.restart = cfg_we;
		unique case (state_q)
			ST_IDLE: begin
				cmd.take = in_valid;
				if (in_valid && stat.emit) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_GATHER;
			end
			ST_GATHER: begin
				cmd.gather = 1'b1;
				if (stat.gather_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_FINISH;
			end
			ST_FINISH: begin
				cmd.step = 1'b1;
				if (stat.step_last) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.advance = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/window_mean_median_filter_unit.sv @@
// Top level of the n-by-n RGB window mean/median filter.
// Holds the configuration registers and the output register; depends on
// wmmf_pkg, wmmf_ctrl and wmmf_dp.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid/s_tready    tdata red,green,blue; tuser command
// m_*       out        m_tvalid/m_tready    tdata red,green,blue; tlast frame end
// cfg_*     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// An item that yields no result is taken while the controller stays idle. An
// item with a result of cnt window samples passes setup, gather, flush, prep,
// finish (eight divider steps in mean mode) and result hand-off; the single
// line-store read port fetches one sample per cycle in gather. Reset clears
// the frame counters and control state, not the line store. A result waiting
// on m_tready stalls the following item's result hand-off, and input with it.
module window_mean_median_filter_unit import wmmf_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = DefMaxWidth,
	parameter int unsigned MAX_WINDOW = DefMaxWindow
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [PixW-1:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	input  logic            s_tuser,   // command
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [PixW-1:0] m_tdata,   // red_out [7:0], green_out [15:8], blue_out [23:16]
	output logic            m_tlast,   // frame_end
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	cfg_t            cfg_q;
	dp_cmd_t         cmd;
	dp_stat_t        stat;
	logic [PixW-1:0] res_pix;
	logic            res_last;
	logic            cfg_we;
	logic            m_tvalid_q;
	logic [PixW-1:0] m_tdata_q;
	logic            m_tlast_q;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= WidthReset;
			cfg_q.height <= HeightReset;
			cfg_q.wsize  <= WsizeReset;
			cfg_q.mode   <= MODE_MEAN;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_WIDTH:  cfg_q.width  <= cfg_data[10:0];
				REG_HEIGHT: cfg_q.height <= cfg_data;
				REG_WSIZE:  cfg_q.wsize  <= cfg_data[2:0];
				REG_MODE:   cfg_q.mode   <= cfg_data[0];
				default:    cfg_q.mode   <= cfg_q.mode;
			endcase
		end
	end

	wmmf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.out_free(!m_tvalid_q || m_tready),
		.cfg_we  (cfg_we),
		.stat    (stat),
		.cmd     (cmd)
	);

	wmmf_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.stat    (stat),
		.pix_cmd (s_tuser),
		.pix_in  (s_tdata),
		.res_pix (res_pix),
		.res_last(res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			m_tdata_q <= res_pix;
			m_tlast_q <= res_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

@@ design/wmmf_checker.sv @@
// Port-level checks of the window filter, bound to the top level.
// Depends on wmmf_pkg and window_mean_median_filter_unit.
module wmmf_checker import wmmf_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [PixW-1:0] s_tdata,
	input logic            s_tuser,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [PixW-1:0] m_tdata,
	input logic            m_tlast,
	input logic            cfg_valid,
	input logic            cfg_ready,
	input logic [1:0]      cfg_index,
	input logic [15:0]     cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_new_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while input side was idle");

	a_result_takes_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready, 2))
		else $error("result appeared too soon after an input transfer");

endmodule

bind window_mean_median_filter_unit wmmf_checker u_wmmf_checker (.*);
